// ===== hdl/zrcg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// zrcg_pkg: shared types, constants and functions
// Output image geometry, configuration register codes, the classified item
// carried from the front to the back, and the per-axis band classifier.
// ----------------------------------------------------------------------------
package zrcg_pkg;

    // Output image size, powers of two (log2 in 4..12)
    localparam int OUT_WIDTH_LOG2  = 10;
    localparam int OUT_HEIGHT_LOG2 = 10;
    localparam int OUT_WIDTH       = 1 << OUT_WIDTH_LOG2;
    localparam int OUT_HEIGHT      = 1 << OUT_HEIGHT_LOG2;

    // Squared band width and quotient widths
    localparam int BSQ_W = 26;
    localparam int QW    = 38;

    // Queue geometry
    localparam int QD_LOG = 2;
    localparam int QD     = 1 << QD_LOG;

    typedef enum logic [2:0] {
        CFG_CENTER_X    = 3'd0,
        CFG_CENTER_Y    = 3'd1,
        CFG_ZONE_WIDTH  = 3'd2,
        CFG_ZONE_HEIGHT = 3'd3,
        CFG_ZOOM        = 3'd4,
        CFG_IN_WIDTH    = 3'd5,
        CFG_IN_HEIGHT   = 3'd6
    } t_cfg_idx;

    // One axis after classification
    typedef struct packed {
        logic               use_zoom;
        logic signed [10:0] dc;
        logic [9:0]         c;
        logic [19:0]        dsq;
        logic [BSQ_W-1:0]   bsq;
    } t_axis_cls;

    // Index 0 is the horizontal axis, 1 the vertical
    typedef t_axis_cls [1:0] t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // One lane of the restoring divider
    typedef struct packed {
        logic               use_zoom;
        logic               neg;
        logic signed [10:0] dc;
        logic [9:0]         c;
        logic [BSQ_W-1:0]   bsq;
        logic [BSQ_W-1:0]   rem;
        logic [QW-1:0]      dq;
    } t_lane_div;

    // Find the zone or band of a pixel and the squared terms of the blend
    function automatic t_axis_cls classify(
        logic [9:0]  p,
        logic [9:0]  c,
        logic [10:0] zone,
        logic [12:0] out_size
    );
        t_axis_cls          r;
        logic [9:0]         h;
        logic signed [11:0] dc12;
        logic [9:0]         adist;
        logic signed [13:0] band;
        logic signed [13:0] dd;
        logic [12:0]        bmag;
        logic [9:0]         d;
        h    = zone[10:1];
        dc12 = $signed({2'b00, p}) - $signed({2'b00, c});
        adist = dc12[11] ? 10'(-dc12) : dc12[9:0];
        if (p > c) begin
            band = $signed({1'b0, out_size}) - $signed({4'b0, c}) - $signed({4'b0, h});
            dd   = $signed({4'b0, p}) - $signed({4'b0, c}) - $signed({4'b0, h});
        end else begin
            band = $signed({4'b0, c}) - $signed({4'b0, h});
            dd   = $signed({4'b0, c}) - $signed({4'b0, h}) - $signed({4'b0, p});
        end
        bmag       = band[13] ? 13'(-band) : band[12:0];
        d          = dd[9:0];
        r.use_zoom = (adist < h) || (band == 14'sd0);
        r.dc       = dc12[10:0];
        r.c        = c;
        r.dsq      = d * d;
        r.bsq      = bmag * bmag;
        return r;
    endfunction

    // One quotient bit of the restoring divider
    function automatic t_lane_div div_step(t_lane_div s);
        t_lane_div      n;
        logic [BSQ_W:0] t;
        n = s;
        t = {s.rem, s.dq[QW-1]};
        if (t >= {1'b0, s.bsq}) begin
            n.rem = BSQ_W'(t - {1'b0, s.bsq});
            n.dq  = {s.dq[QW-2:0], 1'b1};
        end else begin
            n.rem = t[BSQ_W-1:0];
            n.dq  = {s.dq[QW-2:0], 1'b0};
        end
        return n;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/zrcg_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// zrcg_front: request intake and classification
// Takes a pixel request when the queue has room and classifies each axis
// into the central zone or a band, with the squared band terms.
// ----------------------------------------------------------------------------
module zrcg_front (
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire logic [9:0]    i_pixel_x,
    input  wire logic [9:0]    i_pixel_y,
    input  wire logic [9:0]    i_center_x,
    input  wire logic [9:0]    i_center_y,
    input  wire logic [10:0]   i_zone_width,
    input  wire logic [10:0]   i_zone_height,
    input  wire zrcg_pkg::t_q_status i_q_stat,
    output logic               o_push,
    output zrcg_pkg::t_item    o_push_data
);

    // Accept while the queue has room
    assign o_in_ready = !i_q_stat.full;
    assign o_push     = i_in_valid && !i_q_stat.full;

    // Classify both axes
    always_comb begin
        o_push_data[0] = zrcg_pkg::classify(i_pixel_x, i_center_x, i_zone_width,
                                            13'(zrcg_pkg::OUT_WIDTH));
        o_push_data[1] = zrcg_pkg::classify(i_pixel_y, i_center_y, i_zone_height,
                                            13'(zrcg_pkg::OUT_HEIGHT));
    end

endmodule
`default_nettype wire

// ===== hdl/zrcg_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// zrcg_queue: short request queue
// Small first-in first-out buffer between the front and the back.
// ----------------------------------------------------------------------------
module zrcg_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire zrcg_pkg::t_item    i_push_data,
    input  wire logic               i_pop,
    output zrcg_pkg::t_item         o_pop_data,
    output zrcg_pkg::t_q_status     o_stat
);

    zrcg_pkg::t_item r_mem [0:zrcg_pkg::QD-1];
    logic [zrcg_pkg::QD_LOG-1:0] r_wp, n_wp;
    logic [zrcg_pkg::QD_LOG-1:0] r_rp, n_rp;
    logic [zrcg_pkg::QD_LOG:0]   r_cnt, n_cnt;

    // Pointer and fill count update
    always_comb begin
        n_wp  = i_push ? r_wp + 1'b1 : r_wp;
        n_rp  = i_pop ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

    assign o_pop_data   = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == (zrcg_pkg::QD_LOG+1)'(zrcg_pkg::QD));
    assign o_stat.empty = (r_cnt == '0);

endmodule
`default_nettype wire

// ===== hdl/zrcg_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// zrcg_back: coefficient and source position pipeline
// Blends the coefficient through a pipelined divider, maps the pixel,
// scales to the source size, rounds and saturates. One global advance.
// ----------------------------------------------------------------------------
module zrcg_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire zrcg_pkg::t_item    i_q_data,
    input  wire zrcg_pkg::t_q_status i_q_stat,
    output logic                    o_pop,
    input  wire logic [16:0]        i_zoom,
    input  wire logic [12:0]        i_in_width,
    input  wire logic [12:0]        i_in_height,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [23:0]      o_source_x,
    output logic signed [23:0]      o_source_y
);

    localparam int NV = zrcg_pkg::QW + 6;

    logic          adv;
    logic [NV-1:0] r_vld;
    logic          r_ov;
    logic signed [23:0] w_res [0:1];

    // Advance the whole pipeline unless the output is held
    assign adv   = !r_ov || i_out_ready;
    assign o_pop = adv && !i_q_stat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_ov  <= 1'b0;
        end else if (adv) begin
            r_vld <= {r_vld[NV-2:0], o_pop};
            r_ov  <= r_vld[NV-1];
        end
    end

    assign o_out_valid = r_ov;
    assign o_source_x  = w_res[0];
    assign o_source_y  = w_res[1];

    for (genvar a = 0; a < 2; a++) begin : g_axis
        localparam int SH = ((a == 0) ? zrcg_pkg::OUT_WIDTH_LOG2
                                      : zrcg_pkg::OUT_HEIGHT_LOG2) + 8;
        localparam logic signed [51:0] PLIM = 52'sd17592186044416;

        logic [12:0]             in_size;
        logic signed [17:0]      zdiff;
        zrcg_pkg::t_axis_cls     r_b1_cls;
        logic signed [38:0]      r_b1_prod;
        logic signed [38:0]      n_b1_prod;
        zrcg_pkg::t_lane_div     r_div [0:zrcg_pkg::QW];
        logic signed [39:0]      r_coef, n_coef;
        logic signed [10:0]      r_c1_dc;
        logic [9:0]              r_c1_c;
        logic signed [51:0]      r_pos, n_pos, n_mul;
        logic signed [45:0]      r_pc, n_pc;
        logic signed [59:0]      r_x, n_x;
        logic [59:0]             mag, rr;
        logic signed [23:0]      r_out, n_out;

        assign in_size = (a == 0) ? i_in_width : i_in_height;
        assign zdiff   = $signed(18'h10000) - $signed({1'b0, i_zoom});

        // Weight the squared distance by one minus zoom
        assign n_b1_prod = zdiff * $signed({1'b0, i_q_data[a].dsq});

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_b1_cls  <= i_q_data[a];
                r_b1_prod <= n_b1_prod;
            end
        end

        // Load the divider with the magnitude plus half the divisor,
        // then take one quotient bit per stage
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_div[0].use_zoom <= r_b1_cls.use_zoom;
                r_div[0].neg      <= r_b1_prod[38];
                r_div[0].dc       <= r_b1_cls.dc;
                r_div[0].c        <= r_b1_cls.c;
                r_div[0].bsq      <= r_b1_cls.bsq;
                r_div[0].rem      <= '0;
                r_div[0].dq       <= (r_b1_prod[38] ? zrcg_pkg::QW'(-r_b1_prod)
                                                    : zrcg_pkg::QW'(r_b1_prod))
                                     + zrcg_pkg::QW'(r_b1_cls.bsq >> 1);
                for (int k = 0; k < zrcg_pkg::QW; k++) begin
                    r_div[k+1] <= zrcg_pkg::div_step(r_div[k]);
                end
            end
        end

        // Blend the coefficient
        always_comb begin
            if (r_div[zrcg_pkg::QW].use_zoom) begin
                n_coef = $signed({23'd0, i_zoom});
            end else if (r_div[zrcg_pkg::QW].neg) begin
                n_coef = $signed({23'd0, i_zoom}) - $signed({2'b00, r_div[zrcg_pkg::QW].dq});
            end else begin
                n_coef = $signed({23'd0, i_zoom}) + $signed({2'b00, r_div[zrcg_pkg::QW].dq});
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_coef  <= n_coef;
                r_c1_dc <= r_div[zrcg_pkg::QW].dc;
                r_c1_c  <= r_div[zrcg_pkg::QW].c;
            end
        end

        // Map around the centre
        assign n_mul = r_c1_dc * r_coef;
        assign n_pos = $signed({26'd0, r_c1_c, 16'd0}) + n_mul;

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_pos <= n_pos;
            end
        end

        // Clamp the position
        always_comb begin
            if (r_pos > PLIM) begin
                n_pc = 46'(PLIM);
            end else if (r_pos < -PLIM) begin
                n_pc = 46'(-PLIM);
            end else begin
                n_pc = 46'(r_pos);
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_pc <= n_pc;
            end
        end

        // Scale to the source size
        assign n_x = r_pc * $signed({1'b0, in_size});

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_x <= n_x;
            end
        end

        // Round half away from zero and saturate
        always_comb begin
            mag = r_x[59] ? 60'(-r_x) : 60'(r_x);
            rr  = (mag + (60'd1 << (SH - 1))) >> SH;
            if (r_x[59]) begin
                n_out = (rr > 60'd8388608) ? 24'sh800000 : $signed(24'(-rr));
            end else begin
                n_out = (rr > 60'd8388607) ? 24'sh7FFFFF : $signed(rr[23:0]);
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_out <= n_out;
            end
        end

        assign w_res[a] = r_out;
    end

endmodule
`default_nettype wire

// ===== hdl/zoom_remap_coordinate_generator.sv =====
// A request passes the queue, the product, the 38-stage restoring divider per
// axis and the coefficient, position, clamp, scale and output registers.
// Throughput: one request per cycle unless the output is held; all advance together.
// Reset: synchronous, active low; clears queue, valid bits and restores the
// configuration registers to their defaults.
`default_nettype none
// ----------------------------------------------------------------------------
// zoom_remap_coordinate_generator: magnifying remap source coordinates
// Front classifies pixel requests, a short queue decouples, the back
// pipeline computes the saturated source position in 1/256 pixel.
// ----------------------------------------------------------------------------
module zoom_remap_coordinate_generator (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [2:0]    i_cfg_index,
    input  wire logic [16:0]   i_cfg_data,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire logic [9:0]    i_pixel_x,
    input  wire logic [9:0]    i_pixel_y,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output logic signed [23:0] o_source_x,
    output logic signed [23:0] o_source_y
);

    logic [9:0]  r_center_x, r_center_y;
    logic [10:0] r_zone_width, r_zone_height;
    logic [16:0] r_zoom;
    logic [12:0] r_in_width, r_in_height;

    logic                 q_push;
    logic                 q_pop;
    zrcg_pkg::t_item      q_wdata;
    zrcg_pkg::t_item      q_rdata;
    zrcg_pkg::t_q_status  q_stat;

    // Configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x    <= 10'd512;
            r_center_y    <= 10'd512;
            r_zone_width  <= 11'd512;
            r_zone_height <= 11'd512;
            r_zoom        <= 17'd45875;
            r_in_width    <= 13'd1024;
            r_in_height   <= 13'd1024;
        end else if (i_cfg_we) begin
            unique case (zrcg_pkg::t_cfg_idx'(i_cfg_index))
                zrcg_pkg::CFG_CENTER_X:    r_center_x    <= i_cfg_data[9:0];
                zrcg_pkg::CFG_CENTER_Y:    r_center_y    <= i_cfg_data[9:0];
                zrcg_pkg::CFG_ZONE_WIDTH:  r_zone_width  <= i_cfg_data[10:0];
                zrcg_pkg::CFG_ZONE_HEIGHT: r_zone_height <= i_cfg_data[10:0];
                zrcg_pkg::CFG_ZOOM:        r_zoom        <= i_cfg_data;
                zrcg_pkg::CFG_IN_WIDTH:    r_in_width    <= i_cfg_data[12:0];
                zrcg_pkg::CFG_IN_HEIGHT:   r_in_height   <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    zrcg_front u_front (
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_pixel_x     (i_pixel_x),
        .i_pixel_y     (i_pixel_y),
        .i_center_x    (r_center_x),
        .i_center_y    (r_center_y),
        .i_zone_width  (r_zone_width),
        .i_zone_height (r_zone_height),
        .i_q_stat      (q_stat),
        .o_push        (q_push),
        .o_push_data   (q_wdata)
    );

    zrcg_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_wdata),
        .i_pop       (q_pop),
        .o_pop_data  (q_rdata),
        .o_stat      (q_stat)
    );

    zrcg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_data    (q_rdata),
        .i_q_stat    (q_stat),
        .o_pop       (q_pop),
        .i_zoom      (r_zoom),
        .i_in_width  (r_in_width),
        .i_in_height (r_in_height),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_source_x  (o_source_x),
        .o_source_y  (o_source_y)
    );

    // Never write into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full)
        else $error("request pushed into full queue");

    // Never drain an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty)
        else $error("request popped from empty queue");

    // Reset leaves no result pending
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule
`default_nettype wire
